@@ rtl/core/mdx_pkg.sv @@
// Shared types and opcode constants for the decode/execute unit.
`default_nettype none
package mdx_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    // regimm sub-codes (taken from the rt field)
    localparam logic [5:0] RI_BGEZ   = 6'h01;
    localparam logic [5:0] RI_BLTZAL = 6'h10;
    localparam logic [5:0] RI_BGEZAL = 6'h11;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] inst_pc;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } t_mdx_in;

    typedef struct packed {
        logic [31:0] result_value;
        logic [31:0] next_pc;
        logic [4:0]  dest_reg;
        logic        dest_write;
        logic        mem_read;
        logic        mem_write;
        logic        byte_acc;
        logic [31:0] mem_address;
    } t_mdx_out;

    typedef struct packed {
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [31:0] imm;
        logic        is_j;
        logic        is_jr;
        logic        link;
        logic [4:0]  dest_reg;
        logic        dest_write;
        logic        mem_read;
        logic        mem_write;
        logic        byte_acc;
    } t_mdx_ctrl;

endpackage
`default_nettype wire

@@ rtl/core/mips_subset_decode_execute_unit.sv @@
// Top level of the decode/execute unit: input register, decode/execute, result register.
//
// One instruction per clock: a transaction is taken whenever start is high
// and busy is low, and busy is low at all times outside reset. Each
// transaction gives one result after the input register and the result
// register, shown on o_result for a single cycle with o_valid high; the
// receiver must take it then. Decode and execute are done as one pass of
// combinational logic between those two registers.
`default_nettype none
module mips_subset_decode_execute_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mdx_pkg::t_mdx_in  i_item,
    output logic              o_valid,
    output mdx_pkg::t_mdx_out o_result
);
    import mdx_pkg::*;

    logic      r_in_vld;
    t_mdx_in   r_in;
    logic      r_out_vld;
    t_mdx_out  r_out;
    logic      n_in_vld;
    t_mdx_ctrl ctrl;
    t_mdx_out  n_out;

    assign busy     = !i_rst_n;
    assign n_in_vld = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= i_item;
        r_out <= n_out;
    end

    mdx_decode u_decode (
        .i_instruction (r_in.instruction),
        .o_ctrl        (ctrl)
    );

    mdx_execute u_execute (
        .i_item   (r_in),
        .i_ctrl   (ctrl),
        .o_result (n_out)
    );

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_in_vld)
        else $error("accepted transaction not captured");
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_vld))
        else $error("result strobe without a captured transaction");
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.mem_read && o_result.mem_write))
        else $error("load and store flagged together");
    a_byte_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.byte_acc) |-> (o_result.mem_read || o_result.mem_write))
        else $error("byte flag without a memory access");
    a_mem_no_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.mem_write) |-> !o_result.dest_write)
        else $error("store writes a register");
`endif

endmodule
`default_nettype wire

@@ rtl/core/mdx_decode.sv @@
// Instruction decoder: opcode classes, immediate selection and destination.
`default_nettype none
module mdx_decode (
    input  logic [31:0]       i_instruction,
    output mdx_pkg::t_mdx_ctrl o_ctrl
);
    import mdx_pkg::*;

    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rtf;
    logic [4:0] rdf;
    logic       is_j;
    logic       is_shift_imm;
    logic       is_sext;
    logic       link;
    logic       dest_t;

    assign op  = i_instruction[31:26];
    assign rtf = i_instruction[20:16];
    assign rdf = i_instruction[15:11];
    assign fn  = (op == OP_REGIMM) ? {1'b0, rtf} : i_instruction[5:0];

    assign is_j = (op == OP_J) || (op == OP_JAL);
    assign is_shift_imm = (op == OP_SPECIAL) &&
                          ((fn == FN_SLL) || (fn == FN_SRL) || (fn == FN_SRA));
    // slti/sltiu zero-extend, like the logical ops
    assign is_sext = (op == OP_REGIMM) || (op == OP_BEQ) || (op == OP_BNE) ||
                     (op == OP_BLEZ) || (op == OP_BGTZ) || (op == OP_ADDI) ||
                     (op == OP_ADDIU) || (op == OP_LB) || (op == OP_LW) ||
                     (op == OP_SB) || (op == OP_SW);

    assign link = (op == OP_JAL) ||
                  ((op == OP_REGIMM) && ((fn == RI_BLTZAL) || (fn == RI_BGEZAL)));
    assign dest_t = (op == OP_ADDI) || (op == OP_ADDIU) || (op == OP_SLTI) ||
                    (op == OP_SLTIU) || (op == OP_ANDI) || (op == OP_ORI) ||
                    (op == OP_XORI) || (op == OP_LUI) || (op == OP_LB) ||
                    (op == OP_LW);

    always_comb begin
        o_ctrl = '0;
        o_ctrl.op    = op;
        o_ctrl.fn    = fn;
        o_ctrl.is_j  = is_j;
        o_ctrl.is_jr = (op == OP_SPECIAL) && (fn == FN_JR);
        o_ctrl.link  = link;
        priority if (is_j) begin
            o_ctrl.imm = {6'd0, i_instruction[25:0]};
        end else if (is_shift_imm) begin
            o_ctrl.imm = {27'd0, i_instruction[10:6]};
        end else if (is_sext) begin
            o_ctrl.imm = {{16{i_instruction[15]}}, i_instruction[15:0]};
        end else begin
            o_ctrl.imm = {16'd0, i_instruction[15:0]};
        end
        priority if (dest_t) begin
            o_ctrl.dest_reg = rtf;
        end else if (link) begin
            o_ctrl.dest_reg = LINK_REG;
        end else begin
            o_ctrl.dest_reg = rdf;
        end
        o_ctrl.dest_write = (op == OP_SPECIAL) || dest_t || link;
        o_ctrl.mem_read   = (op == OP_LB) || (op == OP_LW);
        o_ctrl.mem_write  = (op == OP_SB) || (op == OP_SW);
        o_ctrl.byte_acc   = (op == OP_LB) || (op == OP_SB);
    end

endmodule
`default_nettype wire

@@ rtl/core/mdx_execute.sv @@
// Execute stage logic: ALU result, next pc and effective address.
`default_nettype none
module mdx_execute (
    input  mdx_pkg::t_mdx_in   i_item,
    input  mdx_pkg::t_mdx_ctrl i_ctrl,
    output mdx_pkg::t_mdx_out  o_result
);
    import mdx_pkg::*;

    logic [31:0] pc;
    logic [31:0] rs;
    logic [31:0] rt;
    logic [31:0] imm;
    logic [31:0] seq;
    logic [31:0] bdest;
    logic [31:0] jdest;
    logic        neg;
    logic        taken;
    logic [31:0] npc;
    logic [31:0] res;
    logic [31:0] alu_r;
    logic [31:0] alu_i;

    assign pc    = i_item.inst_pc;
    assign rs    = i_item.rs_value;
    assign rt    = i_item.rt_value;
    assign imm   = i_ctrl.imm;
    assign seq   = pc + 32'd4;
    assign bdest = seq + {imm[29:0], 2'b00};
    assign jdest = {pc[31:28], imm[25:0], 2'b00};
    assign neg   = rs[31];

    always_comb begin
        unique case (i_ctrl.op)
            OP_BEQ:    taken = (rs == rt);
            OP_BNE:    taken = (rs != rt);
            OP_BLEZ:   taken = (rs == 32'd0) || neg;
            OP_BGTZ:   taken = (rs != 32'd0) && !neg;
            // bltz is not implemented and falls through
            OP_REGIMM: taken = ((i_ctrl.fn == RI_BGEZ) && !neg) ||
                               ((i_ctrl.fn == RI_BLTZAL) && neg) ||
                               ((i_ctrl.fn == RI_BGEZAL) && !neg);
            default:   taken = 1'b0;
        endcase
    end

    always_comb begin
        priority if (i_ctrl.is_j) begin
            npc = jdest;
        end else if (i_ctrl.is_jr) begin
            npc = rs;
        end else if (taken) begin
            npc = bdest;
        end else begin
            npc = seq;
        end
    end

    always_comb begin
        unique case (i_ctrl.fn)
            FN_SLL:           alu_r = rt << imm[4:0];
            FN_SRL:           alu_r = rt >> imm[4:0];
            FN_SRA:           alu_r = 32'($signed(rt) >>> imm[4:0]);
            FN_SLLV:          alu_r = rt << rs[4:0];
            FN_SRLV:          alu_r = rt >> rs[4:0];
            FN_SRAV:          alu_r = 32'($signed(rt) >>> rs[4:0]);
            FN_ADD, FN_ADDU:  alu_r = rs + rt;
            FN_SUB, FN_SUBU:  alu_r = rs - rt;
            FN_AND:           alu_r = rs & rt;
            FN_OR:            alu_r = rs | rt;
            FN_XOR:           alu_r = rs ^ rt;
            FN_SLT:           alu_r = {31'd0, $signed(rs) < $signed(rt)};
            FN_SLTU:          alu_r = {31'd0, rs < rt};
            default:          alu_r = 32'd0;
        endcase
    end

    always_comb begin
        unique case (i_ctrl.op)
            OP_ADDI, OP_ADDIU: alu_i = rs + imm;
            OP_SLTI:           alu_i = {31'd0, $signed(rs) < $signed(imm)};
            OP_SLTIU:          alu_i = {31'd0, rs < imm};
            OP_ANDI:           alu_i = rs & imm;
            OP_ORI:            alu_i = rs | imm;
            OP_XORI:           alu_i = rs ^ imm;
            OP_LUI:            alu_i = {imm[15:0], 16'd0};
            default:           alu_i = 32'd0;
        endcase
    end

    always_comb begin
        priority if (i_ctrl.link) begin
            res = seq;
        end else if (i_ctrl.mem_write) begin
            res = rt;
        end else if (i_ctrl.op == OP_SPECIAL) begin
            res = alu_r;
        end else begin
            res = alu_i;
        end
    end

    always_comb begin
        o_result.result_value = res;
        o_result.next_pc      = npc;
        o_result.dest_reg     = i_ctrl.dest_reg;
        o_result.dest_write   = i_ctrl.dest_write;
        o_result.mem_read     = i_ctrl.mem_read;
        o_result.mem_write    = i_ctrl.mem_write;
        o_result.byte_acc     = i_ctrl.byte_acc;
        o_result.mem_address  = rs + imm;
    end

endmodule
`default_nettype wire
